// ===== design/ute_pkg.sv =====
// Shared types, constants and byte-forming function of the UTF-16 to UTF-8 encoder.
package ute_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_BYTES       = 6;
    localparam int CNT_W           = 3;

    localparam logic [15:0] HIGH_LO  = 16'hD800;
    localparam logic [15:0] HIGH_HI  = 16'hDBFF;
    localparam logic [15:0] LOW_LO   = 16'hDC00;
    localparam logic [15:0] LOW_HI   = 16'hDFFF;
    localparam logic [15:0] ONE_LIM  = 16'h0080;
    localparam logic [15:0] TWO_LIM  = 16'h0800;
    localparam logic [20:0] PLANE1   = 21'h10000;
    localparam logic [7:0]  LEAD2    = 8'hC0;
    localparam logic [7:0]  LEAD3    = 8'hE0;
    localparam logic [7:0]  LEAD4    = 8'hF0;
    localparam logic [7:0]  CONT     = 8'h80;

    // One queue entry: the bytes one input word produces, first byte at index 0.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
    } cmd_t;

    function automatic logic [2:0][7:0] three_bytes(input logic [15:0] u);
        logic [2:0][7:0] b;
        b[0] = LEAD3 | {4'h0, u[15:12]};
        b[1] = CONT | {2'b00, u[11:6]};
        b[2] = CONT | {2'b00, u[5:0]};
        return b;
    endfunction

endpackage

// ===== design/utf16_to_utf8_encoder.sv =====
// Top level of the UTF-16 to UTF-8 encoder.
//
// Input side is a queue write port: code_unit and last_unit are taken at a
// clock edge with push high and full low. Output side is a queue read port:
// while empty is low, utf8_byte and last_byte show the oldest byte, which is
// taken at an edge with pop high. last_byte marks the final byte produced by
// one input unit.
// A high surrogate not flagged last produces no bytes until the next unit.
// The first byte of a unit passes the byte-group queue and then the back
// end's current-group register, behind any bytes not yet popped, before it
// shows on the outputs. The output side moves one byte per cycle while pop
// is high and bytes are ready. A unit yields one to three bytes, four for a
// surrogate pair, three to six with an unpaired high surrogate ahead of it.
// The front end accepts one unit per cycle until the byte-group queue
// (QUEUE_DEPTH entries) fills; full then stays high while pop is held low.
// Reset empties the queue, drops any held high surrogate and raises empty.
module utf16_to_utf8_encoder
#(
    parameter int QUEUE_DEPTH = ute_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] code_unit,
    input  logic        last_unit,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  utf8_byte,
    output logic        last_byte
);

    logic          wr_en;
    ute_pkg::cmd_t wr_cmd;
    logic          rd_en;
    ute_pkg::cmd_t rd_cmd;
    logic          q_empty;

    ute_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .code_unit (code_unit),
        .last_unit (last_unit),
        .wr_en     (wr_en),
        .wr_cmd    (wr_cmd)
    );

    ute_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (wr_en),
        .wr_cmd (wr_cmd),
        .rd_en  (rd_en),
        .rd_cmd (rd_cmd),
        .full   (full),
        .empty  (q_empty)
    );

    ute_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (rd_cmd),
        .q_rd      (rd_en),
        .pop       (pop),
        .empty     (empty),
        .utf8_byte (utf8_byte),
        .last_byte (last_byte)
    );

endmodule

// ===== design/ute_front.sv =====
// Front end: accepts code units, pairs surrogates and forms the byte groups.
module ute_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             full,
    input  logic [15:0]      code_unit,
    input  logic             last_unit,
    output logic             wr_en,
    output ute_pkg::cmd_t    wr_cmd
);

    logic        held_valid_reg;
    logic        held_valid_next;
    logic [15:0] held_high_reg;
    logic [15:0] held_high_next;

    logic            accept;
    logic            is_high;
    logic            is_low;
    logic [20:0]     cp;
    logic [2:0][7:0] held_b;
    logic [2:0][7:0] unit_b;
    logic [1:0]      unit_n;
    ute_pkg::cmd_t   cmd;

    assign accept = push && !full;

    always_comb
    begin
        is_high = code_unit inside {[ute_pkg::HIGH_LO:ute_pkg::HIGH_HI]};
        is_low  = code_unit inside {[ute_pkg::LOW_LO:ute_pkg::LOW_HI]};
        cp      = ute_pkg::PLANE1 + {1'b0, held_high_reg[9:0], 10'b0}
                  + {11'b0, code_unit[9:0]};
        held_b  = ute_pkg::three_bytes(held_high_reg);

        unit_b = '0;
        unit_n = 2'd0;
        if (code_unit < ute_pkg::ONE_LIM)
        begin
            unit_b[0] = code_unit[7:0];
            unit_n    = 2'd1;
        end
        else if (code_unit < ute_pkg::TWO_LIM)
        begin
            unit_b[0] = ute_pkg::LEAD2 | {3'b000, code_unit[10:6]};
            unit_b[1] = ute_pkg::CONT | {2'b00, code_unit[5:0]};
            unit_n    = 2'd2;
        end
        else if (is_high && !last_unit)
        begin
            unit_n = 2'd0;
        end
        else
        begin
            unit_b = ute_pkg::three_bytes(code_unit);
            unit_n = 2'd3;
        end

        cmd = '0;
        if (held_valid_reg && is_low)
        begin
            cmd.bytes[0] = ute_pkg::LEAD4 | {5'b0, cp[20:18]};
            cmd.bytes[1] = ute_pkg::CONT | {2'b00, cp[17:12]};
            cmd.bytes[2] = ute_pkg::CONT | {2'b00, cp[11:6]};
            cmd.bytes[3] = ute_pkg::CONT | {2'b00, cp[5:0]};
            cmd.count    = 3'd4;
        end
        else if (held_valid_reg)
        begin
            cmd.bytes[2:0] = held_b;
            cmd.bytes[5:3] = unit_b;
            cmd.count      = 3'd3 + {1'b0, unit_n};
        end
        else
        begin
            cmd.bytes[2:0] = unit_b;
            cmd.count      = {1'b0, unit_n};
        end

        held_valid_next = held_valid_reg;
        held_high_next  = held_high_reg;
        if (accept)
        begin
            held_valid_next = is_high && !last_unit;
            held_high_next  = code_unit;
        end
    end

    assign wr_en  = accept && (cmd.count != '0);
    assign wr_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_high_reg <= held_high_next;
    end

`ifndef SYNTHESIS
    a_last_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_unit |=> !held_valid_reg)
        else $error("high surrogate held past end of string");
`endif

endmodule

// ===== design/ute_fifo.sv =====
// Short show-ahead queue of byte groups between the front and back ends.
module ute_fifo
#(
    parameter int DEPTH = ute_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  ute_pkg::cmd_t wr_cmd,
    input  logic          rd_en,
    output ute_pkg::cmd_t rd_cmd,
    output logic          full,
    output logic          empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ute_pkg::cmd_t  mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_wr;
    logic           do_rd;

    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("word written into full queue");
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) || (count_reg == CW'(DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with fill count");
`endif

endmodule

// ===== design/ute_back.sv =====
// Back end: serializes queued byte groups onto the output queue interface.
module ute_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  ute_pkg::cmd_t q_cmd,
    output logic          q_rd,
    input  logic          pop,
    output logic          empty,
    output logic [7:0]    utf8_byte,
    output logic          last_byte
);

    ute_pkg::cmd_t cur_reg;
    ute_pkg::cmd_t cur_next;
    logic [2:0]    idx_reg;
    logic [2:0]    idx_next;
    logic          busy_reg;
    logic          busy_next;
    logic          at_end;

    assign empty     = !busy_reg;
    assign at_end    = (idx_reg == cur_reg.count - 3'd1);
    assign utf8_byte = cur_reg.bytes[idx_reg];
    assign last_byte = at_end;

    always_comb
    begin
        cur_next  = cur_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        q_rd      = 1'b0;
        if (!busy_reg || (pop && at_end))
        begin
            // load the next group, or go idle
            q_rd      = !q_empty;
            busy_next = !q_empty;
            idx_next  = '0;
            if (!q_empty)
            begin
                cur_next = q_cmd;
            end
        end
        else if (pop)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg < cur_reg.count) && (cur_reg.count != '0))
        else $error("byte index outside current group");
    a_hold_unpopped: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !pop |=> busy_reg && $stable(idx_reg))
        else $error("output word changed while stalled");
`endif

endmodule
